>>> design/ntpc_pkg.sv
// Shared types, constants and calendar helpers for the NTP seconds to calendar converter.
package ntpc_pkg;

   localparam int unsigned SubWidth = 18;

   localparam logic [16:0]         SecondsPerDay    = 17'd86400;
   localparam logic [16:0]         SecondsPerHour   = 17'd3600;
   localparam logic [16:0]         SecondsPerMinute = 17'd60;
   // ceil(2^35/675), ceil(2^21/225), ceil(2^14/15): exact quotients for
   // (seconds >> 7) / 675, (time of day >> 4) / 225 and (seconds of hour >> 2) / 15
   localparam logic [25:0]         DayRecip         = 26'd50903317;
   localparam logic [13:0]         HourRecip        = 14'd9321;
   localparam logic [10:0]         MinuteRecip      = 11'd1093;
   localparam logic [10:0]         EpochYear        = 11'd1900;
   localparam logic [6:0]          EpochYearMod100  = 7'd0;
   localparam logic [1:0]          EpochCentMod4    = 2'd3;
   localparam logic [SubWidth-1:0] DaysCommonYear   = 18'd365;
   localparam logic [SubWidth-1:0] DaysLeapYear     = 18'd366;
   localparam logic [3:0]          LastMonth        = 4'd11;

   typedef logic [SubWidth-1:0] operand_type;

   typedef struct packed {
      logic        ge;
      operand_type diff;
   } sub_result_type;

   // month index 0..11
   function automatic operand_type days_in_month(input logic leap, input logic [3:0] m);
      operand_type d;
      unique case (m)
         4'd1:                         d = leap ? 18'd29 : 18'd28;
         4'd3, 4'd5, 4'd8, 4'd10:      d = 18'd30;
         default:                      d = 18'd31;
      endcase
      return d;
   endfunction

endpackage

>>> design/ntpc_if.sv
// Valid/ready channel interfaces for timestamp request and calendar response beats.
interface ntpc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] ntp_seconds;
   modport source (output valid, output ntp_seconds, input ready);
   modport sink   (input valid, input ntp_seconds, output ready);
endinterface

interface ntpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  day_of_month;
   logic [3:0]  month_number;
   logic [10:0] year_number;
   logic [4:0]  hour_of_day;
   logic [5:0]  minute_of_hour;
   logic [5:0]  second_of_minute;
   modport source (output valid, output day_of_month, output month_number,
                   output year_number, output hour_of_day, output minute_of_hour,
                   output second_of_minute, input ready);
   modport sink   (input valid, input day_of_month, input month_number,
                   input year_number, input hour_of_day, input minute_of_hour,
                   input second_of_minute, output ready);
endinterface

>>> design/ntpc_sub.sv
// Shared compare-and-subtract unit used by the remainder, year and month steps of the conversion sequencer.
module ntpc_sub
   import ntpc_pkg::*;
(
   input  operand_type    sub_a,
   input  operand_type    sub_b,
   output sub_result_type sub_res
);

   logic [SubWidth:0] wide_diff;

   assign wide_diff    = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_res.ge   = ~wide_diff[SubWidth];
   assign sub_res.diff = wide_diff[SubWidth-1:0];

endmodule

>>> design/ntp_seconds_to_calendar_core.sv
// Top level: NTP seconds to Gregorian date and time of day, one shared subtractor.
// Steps from the accepted request beat: days, time of day, hour, hour remainder, minute,
// second remainder, repeated year and month steps, then done until the response is free.
// Days, hours and minutes come from constant reciprocal multiplies, each remainder from one
// pass through the subtractor. One beat at a time; ready only while idle.
// Reset: synchronous, active high; clears the sequencer and the response valid.
module ntp_seconds_to_calendar_core
   import ntpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ntpc_req_if.sink          req_if,
   ntpc_rsp_if.source        rsp_if
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_DAYS  = 10'b0000000010,
      ST_TOD   = 10'b0000000100,
      ST_HOUR  = 10'b0000001000,
      ST_HREM  = 10'b0000010000,
      ST_MIN   = 10'b0000100000,
      ST_SREM  = 10'b0001000000,
      ST_YEAR  = 10'b0010000000,
      ST_MONTH = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type      state_ff, state_in;
   logic [31:0]    secs_ff, secs_in;
   logic [15:0]    days_ff, days_in;
   logic [16:0]    rem_ff, rem_in;
   logic [10:0]    year_ff, year_in;
   logic [6:0]     mod100_ff, mod100_in;
   logic [1:0]     cent4_ff, cent4_in;
   logic [3:0]     month_ff, month_in;
   logic [4:0]     hour_ff, hour_in;
   logic [5:0]     minute_ff, minute_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [4:0]     rsp_day_ff, rsp_day_in;
   logic [3:0]     rsp_month_ff, rsp_month_in;
   logic [10:0]    rsp_year_ff, rsp_year_in;
   logic [4:0]     rsp_hour_ff, rsp_hour_in;
   logic [5:0]     rsp_minute_ff, rsp_minute_in;
   logic [5:0]     rsp_second_ff, rsp_second_in;

   operand_type    sub_a, sub_b;
   sub_result_type sub_res;
   logic           leap;
   logic           req_accept;
   logic           rsp_load;
   logic [50:0]    day_prod;
   logic [26:0]    hour_prod;
   logic [20:0]    minute_prod;
   logic [16:0]    day_secs;
   logic [16:0]    hour_secs;
   logic [16:0]    minute_secs;

   ntpc_sub u_sub (
      .sub_a   (sub_a),
      .sub_b   (sub_b),
      .sub_res (sub_res)
   );

   assign leap       = (year_ff[1:0] == 2'd0) && ((mod100_ff != 7'd0) || (cent4_ff == 2'd0));
   assign req_accept = req_if.valid && req_if.ready;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // quotients by reciprocal multiply, products kept modulo 2^17 for the remainders
   assign day_prod    = {26'd0, secs_ff[31:7]} * {25'd0, DayRecip};
   assign hour_prod   = {14'd0, rem_ff[16:4]} * {13'd0, HourRecip};
   assign minute_prod = {11'd0, rem_ff[11:2]} * {10'd0, MinuteRecip};
   assign day_secs    = {1'b0, days_ff} * SecondsPerDay;
   assign hour_secs   = {12'd0, hour_ff} * SecondsPerHour;
   assign minute_secs = {11'd0, minute_ff} * SecondsPerMinute;

   assign req_if.ready            = (state_ff == ST_IDLE);
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.day_of_month     = rsp_day_ff;
   assign rsp_if.month_number     = rsp_month_ff;
   assign rsp_if.year_number      = rsp_year_ff;
   assign rsp_if.hour_of_day      = rsp_hour_ff;
   assign rsp_if.minute_of_hour   = rsp_minute_ff;
   assign rsp_if.second_of_minute = rsp_second_ff;

   // operand select for the shared unit
   always_comb begin
      unique case (state_ff)
         ST_TOD: begin
            sub_a = {1'b0, secs_ff[16:0]};
            sub_b = {1'b0, day_secs};
         end
         ST_HREM: begin
            sub_a = {1'b0, rem_ff};
            sub_b = {1'b0, hour_secs};
         end
         ST_SREM: begin
            sub_a = {1'b0, rem_ff};
            sub_b = {1'b0, minute_secs};
         end
         ST_YEAR: begin
            sub_a = {2'b00, days_ff};
            sub_b = leap ? DaysLeapYear : DaysCommonYear;
         end
         ST_MONTH: begin
            sub_a = {2'b00, days_ff};
            sub_b = days_in_month(leap, month_ff);
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      secs_in       = secs_ff;
      days_in       = days_ff;
      rem_in        = rem_ff;
      year_in       = year_ff;
      mod100_in     = mod100_ff;
      cent4_in      = cent4_ff;
      month_in      = month_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_day_in    = rsp_day_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_minute_in = rsp_minute_ff;
      rsp_second_in = rsp_second_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               secs_in   = req_if.ntp_seconds;
               year_in   = EpochYear;
               mod100_in = EpochYearMod100;
               cent4_in  = EpochCentMod4;
               month_in  = '0;
               state_in  = ST_DAYS;
            end
         end
         ST_DAYS: begin
            days_in  = day_prod[50:35];
            state_in = ST_TOD;
         end
         ST_TOD: begin
            rem_in   = sub_res.diff[16:0];
            state_in = ST_HOUR;
         end
         ST_HOUR: begin
            hour_in  = hour_prod[25:21];
            state_in = ST_HREM;
         end
         ST_HREM: begin
            rem_in   = sub_res.diff[16:0];
            state_in = ST_MIN;
         end
         ST_MIN: begin
            minute_in = minute_prod[19:14];
            state_in  = ST_SREM;
         end
         ST_SREM: begin
            rem_in   = sub_res.diff[16:0];
            state_in = ST_YEAR;
         end
         ST_YEAR: begin
            if (sub_res.ge) begin
               days_in = sub_res.diff[15:0];
               year_in = year_ff + 11'd1;
               if (mod100_ff == 7'd99) begin
                  mod100_in = '0;
                  cent4_in  = cent4_ff + 2'd1;
               end else begin
                  mod100_in = mod100_ff + 7'd1;
               end
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (month_ff != LastMonth && sub_res.ge) begin
               days_in  = sub_res.diff[15:0];
               month_in = month_ff + 4'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_day_in    = days_ff[4:0] + 5'd1;
               rsp_month_in  = month_ff + 4'd1;
               rsp_year_in   = year_ff;
               rsp_hour_in   = hour_ff;
               rsp_minute_in = minute_ff;
               rsp_second_in = rem_ff[5:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      secs_ff       <= secs_in;
      days_ff       <= days_in;
      rem_ff        <= rem_in;
      year_ff       <= year_in;
      mod100_ff     <= mod100_in;
      cent4_ff      <= cent4_in;
      month_ff      <= month_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_minute_ff <= rsp_minute_in;
      rsp_second_ff <= rsp_second_in;
   end

   a_accept_starts_days: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_DAYS))
      else $error("accepted beat did not start the conversion");

   a_tod_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOUR) |-> (rem_ff < 17'd86400))
      else $error("time of day out of range");

   a_year_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEAR) |-> (year_ff <= 11'd2036) && (rem_ff < 17'd60))
      else $error("year or seconds out of range");

   a_month_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTH) |-> (month_ff <= LastMonth))
      else $error("month index out of range");

   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_day_ff != 5'd0) && (rsp_month_ff != 4'd0)
                       && (rsp_month_ff <= 4'd12) && (rsp_hour_ff <= 5'd23)
                       && (rsp_minute_ff <= 6'd59) && (rsp_second_ff <= 6'd59))
      else $error("response field out of range");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished result not moved to the response register");

endmodule
